// ===== hdl/ddtc_pkg.sv =====
// shared types, constants and helper functions of the tracking controller
package ddtc_pkg;

   // configuration register file
   localparam int CfgCount = 8;
   localparam int CfgW     = 16;
   localparam int CfgIdxW  = 3;

   localparam logic [CfgIdxW-1:0] RegGainX      = 3'd0;
   localparam logic [CfgIdxW-1:0] RegGainY      = 3'd1;
   localparam logic [CfgIdxW-1:0] RegOffsetB    = 3'd2;
   localparam logic [CfgIdxW-1:0] RegInverseB   = 3'd3;
   localparam logic [CfgIdxW-1:0] RegHalfRadius = 3'd4;
   localparam logic [CfgIdxW-1:0] RegRadTrack   = 3'd5;
   localparam logic [CfgIdxW-1:0] RegCtrlPeriod = 3'd6;
   localparam logic [CfgIdxW-1:0] RegTickPeriod = 3'd7;

   localparam logic [CfgW-1:0] CfgReset [CfgCount] =
      '{16'd1280, 16'd1280, 16'd6554, 16'd2560, 16'd2933, 16'd17509, 16'd655, 16'd66};

   // trig unit
   localparam int TrigIterDefault = 16;
   localparam logic signed [33:0] CordicStart = 34'sd652032874;
   // 32768/pi in Q16.16
   localparam logic signed [33:0] Rad2Bam     = 34'sd683565276;

   // shared multiplier widths
   localparam int MulAW = 36;
   localparam int MulBW = 34;
   localparam int ProdW = MulAW + MulBW;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_STEP  = 2'd1,
      OP_LOAD  = 2'd2,
      OP_SPARE = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_OMEGA, MUL_VEL, MUL_DS, MUL_RAD_CTRL, MUL_RAD_TICK, MUL_BAM,
      MUL_POSE_X, MUL_POSE_Y, MUL_PX, MUL_PY, MUL_L1, MUL_L2, MUL_A1, MUL_A2, MUL_ANG
   } mul_sel_type;

   typedef enum logic [4:0] {
      POST_NONE, POST_OMEGA, POST_VEL, POST_DS, POST_RAD, POST_HALF, POST_TICK,
      POST_POSE_X, POST_POSE_Y, POST_ERR, POST_PX, POST_PY, POST_ACC, POST_LIN,
      POST_TURN, POST_ANG, POST_OUT
   } post_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_OMEGA_M, ST_OMEGA_P, ST_VEL_M, ST_VEL_P, ST_DS_M, ST_DS_P,
      ST_RAD_M, ST_RAD_P, ST_BAM_M, ST_BAM_P, ST_MID_GO, ST_MID_ROT,
      ST_POSEX_M, ST_POSEX_P, ST_POSEY_M, ST_POSEY_P, ST_HEAD_GO, ST_HEAD_ROT,
      ST_GX_M, ST_GX_P, ST_GY_M, ST_GY_P, ST_L1_M, ST_L1_P, ST_L2_M, ST_L2_P,
      ST_A1_M, ST_A1_P, ST_A2_M, ST_A2_P, ST_ANG_M, ST_ANG_P, ST_OUT
   } state_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      post_type    post;
      logic        capture;
      logic        load_pose;
      logic        cordic_load;
      logic        cordic_step;
      logic        cordic_head;
   } dp_cmd_type;

   typedef struct packed {
      logic cordic_last;
   } dp_status_type;

   // arctangent of 2^-i as binary angle scaled by 2^16
   function automatic logic [30:0] atan_entry(input logic [4:0] idx);
      logic [30:0] val;
      case (idx)
         5'd0:  val = 31'd536870912;
         5'd1:  val = 31'd316933406;
         5'd2:  val = 31'd167458907;
         5'd3:  val = 31'd85004756;
         5'd4:  val = 31'd42667331;
         5'd5:  val = 31'd21354465;
         5'd6:  val = 31'd10679838;
         5'd7:  val = 31'd5340245;
         5'd8:  val = 31'd2670163;
         5'd9:  val = 31'd1335087;
         5'd10: val = 31'd667544;
         5'd11: val = 31'd333772;
         5'd12: val = 31'd166886;
         5'd13: val = 31'd83443;
         5'd14: val = 31'd41722;
         5'd15: val = 31'd20861;
         5'd16: val = 31'd10430;
         5'd17: val = 31'd5215;
         5'd18: val = 31'd2608;
         5'd19: val = 31'd1304;
         5'd20: val = 31'd652;
         5'd21: val = 31'd326;
         5'd22: val = 31'd163;
         5'd23: val = 31'd81;
         default: val = 31'd0;
      endcase
      return val;
   endfunction

   // shift right rounding to nearest, ties up
   function automatic logic signed [ProdW-1:0] rnd_shift(input logic signed [ProdW-1:0] v,
                                                       input int unsigned sh);
      logic signed [ProdW-1:0] bias;
      bias = ProdW'(1) <<< (sh - 1);
      return (v + bias) >>> sh;
   endfunction

   // clamp to 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
      logic signed [31:0] res;
      if (v > ProdW'(64'sd2147483647)) res = 32'sh7fffffff;
      else if (v < -ProdW'(64'sd2147483648)) res = 32'sh80000000;
      else res = v[31:0];
      return res;
   endfunction

endpackage

// ===== hdl/ddtc_channels.sv =====
// request and response channel interfaces of the tracking controller
interface ddtc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [15:0] start_heading;

   modport source (output valid, opcode, left_speed, right_speed, target_x, target_y,
                   start_heading, input ready);
   modport sink (input valid, opcode, left_speed, right_speed, target_x, target_y,
                 start_heading, output ready);
endinterface

interface ddtc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] linear_velocity;
   logic signed [31:0] angular_velocity;
   logic signed [31:0] error_x;
   logic signed [31:0] error_y;

   modport source (output valid, linear_velocity, angular_velocity, error_x, error_y,
                   input ready);
   modport sink (input valid, linear_velocity, angular_velocity, error_x, error_y,
                 output ready);
endinterface

// ===== hdl/ddtc_dp.sv =====
// datapath: config registers, pose state, shared multiplier and cordic unit
module ddtc_dp #(
   parameter int TRIG_ITERATIONS = ddtc_pkg::TrigIterDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ddtc_pkg::CfgIdxW-1:0]    csr_index,
   input  logic [ddtc_pkg::CfgW-1:0]       csr_write_data,
   input  ddtc_pkg::dp_cmd_type            cmd,
   output ddtc_pkg::dp_status_type         status,
   input  logic signed [15:0]              left_speed,
   input  logic signed [15:0]              right_speed,
   input  logic signed [31:0]              target_x,
   input  logic signed [31:0]              target_y,
   input  logic signed [15:0]              start_heading,
   output logic signed [31:0]              linear_velocity,
   output logic signed [31:0]              angular_velocity,
   output logic signed [31:0]              error_x,
   output logic signed [31:0]              error_y
);
   import ddtc_pkg::*;

   localparam int CntW = $clog2(TRIG_ITERATIONS);
   localparam logic [CntW-1:0] CntLast = CntW'(TRIG_ITERATIONS - 1);

   logic [CfgW-1:0]          cfg_ff [CfgCount];
   logic signed [15:0]       left_ff, right_ff;
   logic signed [31:0]       tx_ff, ty_ff;
   logic signed [31:0]       pose_x_ff, pose_y_ff;
   logic [15:0]              heading_ff, mid_ff;
   logic signed [26:0]       w_ff, v_ff, ds_ff, rad_ff;
   logic signed [32:0]       ex_ff, ey_ff;
   logic signed [31:0]       px_ff, py_ff, lin_ff, ang_ff;
   logic signed [35:0]       turn_ff;
   logic signed [ProdW-1:0]  acc_ff, prod_ff, prod_in;
   logic signed [31:0]       out_lin_ff, out_ang_ff, out_ex_ff, out_ey_ff;
   logic signed [MulAW-1:0]  mul_a;
   logic signed [MulBW-1:0]  mul_b;
   logic signed [16:0]       spd_diff, spd_sum;
   logic signed [ProdW-1:0]  r8, r16, r30, r32, r33;
   logic signed [33:0]       cx_ff, cy_ff, cz_ff, cos_val, sin_val, atan_val;
   logic signed [33:0]       z_init;
   logic                     neg_ff, neg_in;
   logic [CntW-1:0]          cnt_ff;
   logic [15:0]              rot_src;
   logic signed [16:0]       ang17;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else if (csr_write_enable) begin
         cfg_ff[csr_index] <= csr_write_data;
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff  <= left_speed;
         right_ff <= right_speed;
         tx_ff    <= target_x;
         ty_ff    <= target_y;
      end
   end

   assign spd_diff = 17'(right_ff) - 17'(left_ff);
   assign spd_sum  = 17'(right_ff) + 17'(left_ff);

   // cordic outputs with half-turn correction
   assign cos_val = neg_ff ? -cx_ff : cx_ff;
   assign sin_val = neg_ff ? -cy_ff : cy_ff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_OMEGA: begin
            mul_a = MulAW'(spd_diff);
            mul_b = signed'(MulBW'(cfg_ff[RegRadTrack]));
         end
         MUL_VEL: begin
            mul_a = MulAW'(spd_sum);
            mul_b = signed'(MulBW'(cfg_ff[RegHalfRadius]));
         end
         MUL_DS: begin
            mul_a = MulAW'(v_ff);
            mul_b = signed'(MulBW'(cfg_ff[RegCtrlPeriod]));
         end
         MUL_RAD_CTRL: begin
            mul_a = MulAW'(w_ff);
            mul_b = signed'(MulBW'(cfg_ff[RegCtrlPeriod]));
         end
         MUL_RAD_TICK: begin
            mul_a = MulAW'(w_ff);
            mul_b = signed'(MulBW'(cfg_ff[RegTickPeriod]));
         end
         MUL_BAM: begin
            mul_a = MulAW'(rad_ff);
            mul_b = Rad2Bam;
         end
         MUL_POSE_X: begin
            mul_a = MulAW'(ds_ff);
            mul_b = cos_val;
         end
         MUL_POSE_Y: begin
            mul_a = MulAW'(ds_ff);
            mul_b = sin_val;
         end
         MUL_PX: begin
            mul_a = MulAW'(ex_ff);
            mul_b = signed'(MulBW'(cfg_ff[RegGainX]));
         end
         MUL_PY: begin
            mul_a = MulAW'(ey_ff);
            mul_b = signed'(MulBW'(cfg_ff[RegGainY]));
         end
         MUL_L1: begin
            mul_a = MulAW'(px_ff);
            mul_b = cos_val;
         end
         MUL_L2: begin
            mul_a = MulAW'(py_ff);
            mul_b = sin_val;
         end
         MUL_A1: begin
            mul_a = MulAW'(py_ff);
            mul_b = cos_val;
         end
         MUL_A2: begin
            mul_a = MulAW'(px_ff);
            mul_b = sin_val;
         end
         MUL_ANG: begin
            mul_a = turn_ff;
            mul_b = signed'(MulBW'(cfg_ff[RegInverseB]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign r8  = rnd_shift(prod_ff, 8);
   assign r16 = rnd_shift(prod_ff, 16);
   assign r30 = rnd_shift(prod_ff, 30);
   assign r32 = rnd_shift(prod_ff, 32);
   assign r33 = rnd_shift(prod_ff, 33);

   // work registers fed from the product
   always_ff @(posedge clock) begin
      case (cmd.post)
         POST_OMEGA: w_ff   <= 27'(-r8);
         POST_VEL:   v_ff   <= 27'(r8);
         POST_DS:    ds_ff  <= 27'(r16);
         POST_RAD:   rad_ff <= 27'(r16);
         POST_HALF:  mid_ff <= heading_ff + r33[15:0];
         POST_ERR: begin
            ex_ff <= 33'(tx_ff) - 33'(pose_x_ff);
            ey_ff <= 33'(ty_ff) - 33'(pose_y_ff);
         end
         POST_PX:    px_ff  <= sat32(r8);
         POST_PY:    py_ff  <= sat32(r8);
         POST_ACC:   acc_ff <= prod_ff;
         POST_LIN:   lin_ff <= sat32(rnd_shift(acc_ff + prod_ff, 30));
         POST_TURN:  turn_ff <= 36'(rnd_shift(acc_ff - prod_ff, 30));
         POST_ANG:   ang_ff <= sat32(r8);
         POST_OUT: begin
            out_lin_ff <= lin_ff;
            out_ang_ff <= ang_ff;
            out_ex_ff  <= sat32(ProdW'(ex_ff));
            out_ey_ff  <= sat32(ProdW'(ey_ff));
         end
         default: ;
      endcase
   end

   // pose and heading state
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
      end else if (cmd.load_pose) begin
         pose_x_ff  <= target_x;
         pose_y_ff  <= target_y;
         heading_ff <= start_heading;
      end else begin
         case (cmd.post)
            POST_TICK:   heading_ff <= heading_ff + r32[15:0];
            POST_POSE_X: pose_x_ff  <= sat32(ProdW'(pose_x_ff) + r30);
            POST_POSE_Y: pose_y_ff  <= sat32(ProdW'(pose_y_ff) + r30);
            default: ;
         endcase
      end
   end

   // fold angle into +-pi/2 before rotation
   always_comb begin
      rot_src = cmd.cordic_head ? heading_ff : mid_ff;
      ang17   = 17'(signed'(rot_src));
      neg_in  = 1'b0;
      if (ang17 > 17'sd16384) begin
         ang17  = ang17 - 17'sd32768;
         neg_in = 1'b1;
      end else if (ang17 < -17'sd16384) begin
         ang17  = ang17 + 17'sd32768;
         neg_in = 1'b1;
      end
      z_init = 34'(ang17) <<< 16;
   end

   assign atan_val = signed'(34'(atan_entry(5'(cnt_ff))));

   // cordic iteration, one micro-rotation a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cordic_load) begin
         cnt_ff <= '0;
      end else if (cmd.cordic_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cordic_load) begin
         cx_ff  <= CordicStart;
         cy_ff  <= '0;
         cz_ff  <= z_init;
         neg_ff <= neg_in;
      end else if (cmd.cordic_step) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - (cy_ff >>> cnt_ff);
            cy_ff <= cy_ff + (cx_ff >>> cnt_ff);
            cz_ff <= cz_ff - atan_val;
         end else begin
            cx_ff <= cx_ff + (cy_ff >>> cnt_ff);
            cy_ff <= cy_ff - (cx_ff >>> cnt_ff);
            cz_ff <= cz_ff + atan_val;
         end
      end
   end

   assign status.cordic_last = (cnt_ff == CntLast);

   assign linear_velocity  = out_lin_ff;
   assign angular_velocity = out_ang_ff;
   assign error_x          = out_ex_ff;
   assign error_y          = out_ey_ff;

   // pose load takes the word as given
   a_load_pose: assert property (@(posedge clock) disable iff (reset)
      cmd.load_pose |=> (pose_x_ff == $past(target_x)) && (heading_ff == $past(start_heading)))
      else $error("pose load mismatch");

   // iteration count restarts on each rotation
   a_cordic_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_load |=> cnt_ff == '0)
      else $error("cordic counter not restarted");

   // pose holds when no update is commanded
   a_pose_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.post == POST_NONE) && !cmd.load_pose
         |=> $stable(pose_x_ff) && $stable(pose_y_ff) && $stable(heading_ff))
      else $error("pose changed without command");

endmodule

// ===== hdl/ddtc_ctrl.sv =====
// controller: sequences the datapath for tick, control step and pose load
module ddtc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  ddtc_pkg::opcode_type     req_opcode,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ddtc_pkg::dp_cmd_type     cmd,
   input  ddtc_pkg::dp_status_type  status
);
   import ddtc_pkg::*;

   state_type state_ff, state_in;
   logic      tick_ff, tick_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_TICK || req_opcode == OP_STEP))
               state_in = ST_OMEGA_M;
         end
         ST_OMEGA_M:  state_in = ST_OMEGA_P;
         ST_OMEGA_P:  state_in = tick_ff ? ST_RAD_M : ST_VEL_M;
         ST_VEL_M:    state_in = ST_VEL_P;
         ST_VEL_P:    state_in = ST_DS_M;
         ST_DS_M:     state_in = ST_DS_P;
         ST_DS_P:     state_in = ST_RAD_M;
         ST_RAD_M:    state_in = ST_RAD_P;
         ST_RAD_P:    state_in = ST_BAM_M;
         ST_BAM_M:    state_in = ST_BAM_P;
         ST_BAM_P:    state_in = tick_ff ? ST_IDLE : ST_MID_GO;
         ST_MID_GO:   state_in = ST_MID_ROT;
         ST_MID_ROT:  state_in = status.cordic_last ? ST_POSEX_M : ST_MID_ROT;
         ST_POSEX_M:  state_in = ST_POSEX_P;
         ST_POSEX_P:  state_in = ST_POSEY_M;
         ST_POSEY_M:  state_in = ST_POSEY_P;
         ST_POSEY_P:  state_in = ST_HEAD_GO;
         ST_HEAD_GO:  state_in = ST_HEAD_ROT;
         ST_HEAD_ROT: state_in = status.cordic_last ? ST_GX_M : ST_HEAD_ROT;
         ST_GX_M:     state_in = ST_GX_P;
         ST_GX_P:     state_in = ST_GY_M;
         ST_GY_M:     state_in = ST_GY_P;
         ST_GY_P:     state_in = ST_L1_M;
         ST_L1_M:     state_in = ST_L1_P;
         ST_L1_P:     state_in = ST_L2_M;
         ST_L2_M:     state_in = ST_L2_P;
         ST_L2_P:     state_in = ST_A1_M;
         ST_A1_M:     state_in = ST_A1_P;
         ST_A1_P:     state_in = ST_A2_M;
         ST_A2_M:     state_in = ST_A2_P;
         ST_A2_P:     state_in = ST_ANG_M;
         ST_ANG_M:    state_in = ST_ANG_P;
         ST_ANG_P:    state_in = ST_OUT;
         ST_OUT:      state_in = out_free ? ST_IDLE : ST_OUT;
      endcase
   end

   // datapath commands
   always_comb begin
      req_ready       = 1'b0;
      cmd.mul_sel     = MUL_NONE;
      cmd.post        = POST_NONE;
      cmd.capture     = 1'b0;
      cmd.load_pose   = 1'b0;
      cmd.cordic_load = 1'b0;
      cmd.cordic_step = 1'b0;
      cmd.cordic_head = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.capture   = accept;
            cmd.load_pose = accept && (req_opcode == OP_LOAD);
         end
         ST_OMEGA_M:  cmd.mul_sel = MUL_OMEGA;
         ST_OMEGA_P:  cmd.post    = POST_OMEGA;
         ST_VEL_M:    cmd.mul_sel = MUL_VEL;
         ST_VEL_P:    cmd.post    = POST_VEL;
         ST_DS_M:     cmd.mul_sel = MUL_DS;
         ST_DS_P:     cmd.post    = POST_DS;
         ST_RAD_M:    cmd.mul_sel = tick_ff ? MUL_RAD_TICK : MUL_RAD_CTRL;
         ST_RAD_P:    cmd.post    = POST_RAD;
         ST_BAM_M:    cmd.mul_sel = MUL_BAM;
         ST_BAM_P:    cmd.post    = tick_ff ? POST_TICK : POST_HALF;
         ST_MID_GO:   cmd.cordic_load = 1'b1;
         ST_MID_ROT:  cmd.cordic_step = 1'b1;
         ST_POSEX_M:  cmd.mul_sel = MUL_POSE_X;
         ST_POSEX_P:  cmd.post    = POST_POSE_X;
         ST_POSEY_M:  cmd.mul_sel = MUL_POSE_Y;
         ST_POSEY_P:  cmd.post    = POST_POSE_Y;
         ST_HEAD_GO: begin
            cmd.cordic_load = 1'b1;
            cmd.cordic_head = 1'b1;
            cmd.post        = POST_ERR;
         end
         ST_HEAD_ROT: cmd.cordic_step = 1'b1;
         ST_GX_M:     cmd.mul_sel = MUL_PX;
         ST_GX_P:     cmd.post    = POST_PX;
         ST_GY_M:     cmd.mul_sel = MUL_PY;
         ST_GY_P:     cmd.post    = POST_PY;
         ST_L1_M:     cmd.mul_sel = MUL_L1;
         ST_L1_P:     cmd.post    = POST_ACC;
         ST_L2_M:     cmd.mul_sel = MUL_L2;
         ST_L2_P:     cmd.post    = POST_LIN;
         ST_A1_M:     cmd.mul_sel = MUL_A1;
         ST_A1_P:     cmd.post    = POST_ACC;
         ST_A2_M:     cmd.mul_sel = MUL_A2;
         ST_A2_P:     cmd.post    = POST_TURN;
         ST_ANG_M:    cmd.mul_sel = MUL_ANG;
         ST_ANG_P:    cmd.post    = POST_ANG;
         ST_OUT: begin
            if (out_free) cmd.post = POST_OUT;
         end
      endcase
   end

   // response valid and item kind
   assign rsp_valid_in = ((state_ff == ST_OUT) && out_free) || (rsp_valid_ff && !rsp_ready);
   assign tick_in      = accept ? (req_opcode == OP_TICK) : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result only comes out of the final state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside final state");

   // a waiting result is never overwritten
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && !rsp_ready |=> state_ff == ST_OUT)
      else $error("final state left while result pending");

   // a control step or tick starts the sequence
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_STEP || req_opcode == OP_TICK) |=> state_ff == ST_OMEGA_M)
      else $error("accepted word did not start sequence");

endmodule

// ===== hdl/diff_drive_tracking_controller.sv =====
// top level of the differential-drive tracking controller
// Takes one request word at a time and never overlaps two. A pose load
// (opcode 2) finishes in the accepting cycle and an unused opcode is dropped.
// A heading tick (opcode 0) forms the omega, radian and binary-angle products
// and then updates the heading. The length of a control step (opcode 1) is set
// by the single shared multiplier, which forms fourteen products one after
// another, and by the iterative cordic, which runs twice per step at one
// micro-rotation a cycle. The result sits in an output register, so the next
// request is accepted while it waits; a later control step holds in its final
// state until that result has been taken. Config writes land at once.
module diff_drive_tracking_controller #(
   parameter int TRIG_ITERATIONS = ddtc_pkg::TrigIterDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   ddtc_req_if.sink                     req_chan,
   ddtc_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [ddtc_pkg::CfgIdxW-1:0] csr_index,
   input  logic [ddtc_pkg::CfgW-1:0]    csr_write_data
);
   import ddtc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // sequencer
   ddtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (opcode_type'(req_chan.opcode)),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   // arithmetic and state
   ddtc_dp #(
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .left_speed       (req_chan.left_speed),
      .right_speed      (req_chan.right_speed),
      .target_x         (req_chan.target_x),
      .target_y         (req_chan.target_y),
      .start_heading    (req_chan.start_heading),
      .linear_velocity  (rsp_chan.linear_velocity),
      .angular_velocity (rsp_chan.angular_velocity),
      .error_x          (rsp_chan.error_x),
      .error_y          (rsp_chan.error_y)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

// ===== tb/diff_drive_tracking_controller_tb.sv =====
// self-checking testbench of the differential-drive tracking controller
module diff_drive_tracking_controller_tb;
   import ddtc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TrigIter    = 16;
   localparam int CycleLimit  = 2000000;
   localparam int SettleWait  = 100;
   localparam int IdlePercent = 28;
   localparam int HoldCycles  = 600;
   localparam longint BamScale = 64'sd683565276;
   localparam longint TrigGain = 64'sd652032874;

   // arctangent of 2^-i in binary angle units times 2^16
   localparam longint AtanStep [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861};

   typedef struct {
      opcode_type         op;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [15:0] head;
   } motion_word_type;

   typedef struct {
      logic signed [31:0] lin;
      logic signed [31:0] ang;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
   } command_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [CfgIdxW-1:0]  csr_index = '0;
   logic [CfgW-1:0]     csr_write_data = '0;

   ddtc_req_if req_chan ();
   ddtc_rsp_if rsp_chan ();

   diff_drive_tracking_controller #(.TRIG_ITERATIONS(TrigIter)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data));

   // shadow of the block's registers and pose
   logic [15:0]        gain_reg [CfgCount];
   logic signed [31:0] track_x, track_y;
   logic [15:0]        track_heading;

   motion_word_type  pending_words [$];
   command_word_type expected_commands [$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  hold_go = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // idling is off in one window out of every four
   function automatic bit idle_now();
      if ((cycle_count / 5000) % 4 == 1) return 1'b0;
      return $urandom_range(99) < IdlePercent;
   endfunction

   function automatic longint round_shift(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // rotation-mode cordic, result Q2.30
   task automatic rotate_unit(input logic [15:0] angle, output longint c, output longint s);
      longint a, x, y, z, nx;
      bit flip;
      a = longint'($signed(angle));
      flip = 1'b0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1'b1;
      end
      x = TrigGain;
      y = 0;
      z = a * 65536;
      for (int i = 0; i < TrigIter; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= AtanStep[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += AtanStep[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint turn_rate(longint l, longint r);
      return -round_shift(longint'(gain_reg[RegRadTrack]) * (r - l), 8);
   endfunction

   function automatic longint heading_delta(longint w, logic [15:0] period, int sh);
      longint rad;
      rad = round_shift(w * longint'(period), 16);
      return round_shift(rad * BamScale, sh);
   endfunction

   // advance the shadow pose and produce the command of a control step
   task automatic track_word(input motion_word_type w, output bit has_cmd,
                             output command_word_type cmd);
      longint l, r, om, v, ds, half, cm, sm, c, s, ex, ey, px, py, an;
      logic [15:0] mid;
      l = longint'(w.left);
      r = longint'(w.right);
      has_cmd = 1'b0;
      case (w.op)
         OP_TICK: begin
            om = turn_rate(l, r);
            track_heading = track_heading
               + 16'(heading_delta(om, gain_reg[RegTickPeriod], 32));
         end
         OP_LOAD: begin
            track_x = w.tx;
            track_y = w.ty;
            track_heading = w.head;
         end
         OP_STEP: begin
            om   = turn_rate(l, r);
            v    = round_shift(longint'(gain_reg[RegHalfRadius]) * (r + l), 8);
            ds   = round_shift(v * longint'(gain_reg[RegCtrlPeriod]), 16);
            half = heading_delta(om, gain_reg[RegCtrlPeriod], 33);
            mid  = track_heading + 16'(half);
            rotate_unit(mid, cm, sm);
            track_x = 32'(clamp32(longint'(track_x) + round_shift(ds * cm, 30)));
            track_y = 32'(clamp32(longint'(track_y) + round_shift(ds * sm, 30)));
            rotate_unit(track_heading, c, s);
            ex = longint'(w.tx) - longint'(track_x);
            ey = longint'(w.ty) - longint'(track_y);
            px = clamp32(round_shift(longint'(gain_reg[RegGainX]) * ex, 8));
            py = clamp32(round_shift(longint'(gain_reg[RegGainY]) * ey, 8));
            an = round_shift(c * py - s * px, 30);
            cmd.lin = 32'(clamp32(round_shift(c * px + s * py, 30)));
            cmd.ang = 32'(clamp32(round_shift(longint'(gain_reg[RegInverseB]) * an, 8)));
            cmd.ex  = 32'(clamp32(ex));
            cmd.ey  = 32'(clamp32(ey));
            has_cmd = 1'b1;
         end
         default: ;
      endcase
   endtask

   // driver: offers queued words, predicts each accepted word
   always @(posedge clock) begin
      motion_word_type w;
      command_word_type cmd;
      bit has_cmd;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            w.op    = opcode_type'(req_chan.opcode);
            w.left  = req_chan.left_speed;
            w.right = req_chan.right_speed;
            w.tx    = req_chan.target_x;
            w.ty    = req_chan.target_y;
            w.head  = req_chan.start_heading;
            track_word(w, has_cmd, cmd);
            if (has_cmd) expected_commands = {expected_commands, cmd};
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() > 0 && !idle_now()) begin
               w = pending_words.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.opcode        <= w.op;
               req_chan.left_speed    <= w.left;
               req_chan.right_speed   <= w.right;
               req_chan.target_x      <= w.tx;
               req_chan.target_y      <= w.ty;
               req_chan.start_heading <= w.head;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted down on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: random back-pressure, field compare
   always @(posedge clock) begin
      command_word_type exp_cmd;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_commands.size() == 0) begin
               $display("%0t: unexpected result word lin=%0d ang=%0d ex=%0d ey=%0d", $time,
                        rsp_chan.linear_velocity, rsp_chan.angular_velocity,
                        rsp_chan.error_x, rsp_chan.error_y);
               error_count++;
            end else begin
               exp_cmd = expected_commands.pop_front();
               if (rsp_chan.linear_velocity !== exp_cmd.lin) begin
                  $display("%0t: linear_velocity expected %0d actual %0d", $time,
                           exp_cmd.lin, rsp_chan.linear_velocity);
                  error_count++;
               end
               if (rsp_chan.angular_velocity !== exp_cmd.ang) begin
                  $display("%0t: angular_velocity expected %0d actual %0d", $time,
                           exp_cmd.ang, rsp_chan.angular_velocity);
                  error_count++;
               end
               if (rsp_chan.error_x !== exp_cmd.ex) begin
                  $display("%0t: error_x expected %0d actual %0d", $time,
                           exp_cmd.ex, rsp_chan.error_x);
                  error_count++;
               end
               if (rsp_chan.error_y !== exp_cmd.ey) begin
                  $display("%0t: error_y expected %0d actual %0d", $time,
                           exp_cmd.ey, rsp_chan.error_y);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !idle_now();
         end
      end
   end

   function automatic motion_word_type make_word(opcode_type op, int l, int r,
                                                 longint tx, longint ty, int head);
      motion_word_type w;
      w.op = op;
      w.left = 16'(l);
      w.right = 16'(r);
      w.tx = 32'(tx);
      w.ty = 32'(ty);
      w.head = 16'(head);
      return w;
   endfunction

   // random word: mostly ticks and control steps near the robot, some noise
   function automatic motion_word_type random_word();
      motion_word_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) w.op = OP_TICK;
      else if (pick < 85) w.op = OP_STEP;
      else if (pick < 95) w.op = OP_LOAD;
      else w.op = OP_SPARE;
      if ($urandom_range(3) == 0) begin
         w.left  = 16'($urandom);
         w.right = 16'($urandom);
      end else begin
         w.left  = 16'($signed($urandom_range(1024)) - 512);
         w.right = 16'($signed($urandom_range(1024)) - 512);
      end
      if ($urandom_range(3) == 0 || w.op == OP_LOAD) begin
         w.tx = 32'($urandom);
         w.ty = 32'($urandom);
      end else begin
         w.tx = 32'($signed($urandom_range(2097152)) - 1048576);
         w.ty = 32'($signed($urandom_range(2097152)) - 1048576);
      end
      w.head = 16'($urandom);
      return w;
   endfunction

   // append one word to the pending list
   task automatic enqueue_word(input motion_word_type w);
      pending_words = {pending_words, w};
   endtask

   task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      gain_reg[idx]     = value;
   endtask

   task automatic write_all(input logic [15:0] values [CfgCount]);
      for (int i = 0; i < CfgCount; i++) write_reg(CfgIdxW'(i), values[i]);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_chan.valid || expected_commands.size() != 0)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic add_random(input int count);
      for (int i = 0; i < count; i++) enqueue_word(random_word());
   endtask

   // stimulus phases
   initial begin
      logic [15:0] cfg_set [CfgCount];
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.left_speed = '0;
      req_chan.right_speed = '0;
      req_chan.target_x = '0;
      req_chan.target_y = '0;
      req_chan.start_heading = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < CfgCount; i++) gain_reg[i] = CfgReset[i];
      track_x = '0;
      track_y = '0;
      track_heading = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings
      enqueue_word(make_word(OP_STEP, 0, 0, 0, 0, 0));
      enqueue_word(make_word(OP_STEP, 256, 256, 65536, -65536, 0));
      enqueue_word(make_word(OP_TICK, -32768, 32767, 0, 0, 0));
      enqueue_word(make_word(OP_TICK, 32767, -32768, 0, 0, 0));
      enqueue_word(make_word(OP_SPARE, 32767, 32767, -1, -1, -1));
      enqueue_word(make_word(OP_LOAD, 0, 0, 0, 0, 32767));
      enqueue_word(make_word(OP_TICK, 0, 32767, 0, 0, 0));
      enqueue_word(make_word(OP_STEP, 32767, 32767, 2147483647, -2147483648, 0));
      enqueue_word(make_word(OP_LOAD, 0, 0, -2147483648, 2147483647, -32768));
      enqueue_word(make_word(OP_STEP, -32768, -32768, 2147483647, -2147483648, 0));
      enqueue_word(make_word(OP_LOAD, 0, 0, 2147483600, 2147483600, 0));
      for (int i = 0; i < 4; i++)
         enqueue_word(make_word(OP_STEP, 32767, 32767, 0, 0, 0));
      enqueue_word(make_word(OP_LOAD, 0, 0, 0, 0, 16384));
      enqueue_word(make_word(OP_STEP, 100, -100, 0, 0, 0));
      enqueue_word(make_word(OP_LOAD, 0, 0, 0, 0, -16385));
      enqueue_word(make_word(OP_STEP, -100, 100, 123456, -654321, 0));
      add_random(500);
      hold_go <= 1'b1;
      drain();

      // all registers at their top
      for (int i = 0; i < CfgCount; i++) cfg_set[i] = 16'hffff;
      write_all(cfg_set);
      enqueue_word(make_word(OP_LOAD, 0, 0, 2147000000, -2147000000, 8192));
      for (int i = 0; i < 6; i++)
         enqueue_word(make_word(OP_STEP, 32767, 32767, 0, 0, 0));
      add_random(300);
      drain();

      // registers at their bottom
      cfg_set = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1};
      write_all(cfg_set);
      add_random(300);
      drain();

      // random settings
      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < CfgCount; i++) cfg_set[i] = 16'($urandom);
         if (cfg_set[RegInverseB] == 0) cfg_set[RegInverseB] = 16'd1;
         if (cfg_set[RegCtrlPeriod] == 0) cfg_set[RegCtrlPeriod] = 16'd1;
         if (cfg_set[RegTickPeriod] == 0) cfg_set[RegTickPeriod] = 16'd1;
         write_all(cfg_set);
         add_random(260);
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== diff_drive_tracking_controller.f =====
hdl/ddtc_pkg.sv
hdl/ddtc_channels.sv
hdl/ddtc_dp.sv
hdl/ddtc_ctrl.sv
hdl/diff_drive_tracking_controller.sv
tb/diff_drive_tracking_controller_tb.sv
